>>> sv/rar_pkg.sv
// shared types and constants for the rational arithmetic and reduction block
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int PROD_WIDTH        = 32;
    localparam int SHIFT_WIDTH       = $clog2(PROD_WIDTH);
    localparam int DIV_CNT_WIDTH     = $clog2(PROD_WIDTH);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        MUL_P1 = 2'd0,
        MUL_P2 = 2'd1,
        MUL_P3 = 2'd2
    } mul_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_MUL1  = 3'd1,
        ST_MUL2  = 3'd2,
        ST_MUL3  = 3'd3,
        ST_SETUP = 3'd4,
        ST_GCD   = 3'd5,
        ST_DIV   = 3'd6,
        ST_FIN   = 3'd7
    } state_t;

    typedef struct packed {
        logic       load_in;
        logic       mul_en;
        mul_phase_t mul_phase;
        logic       setup;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic skip;
        logic gcd_done;
    } status_t;

endpackage

>>> sv/rar_req_if.sv
// request channel: operation and two fractions
interface rar_req_if #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
);
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic signed [OPERAND_WIDTH-1:0] left_num;
    logic [OPERAND_WIDTH-2:0]        left_den;
    logic signed [OPERAND_WIDTH-1:0] right_num;
    logic [OPERAND_WIDTH-2:0]        right_den;

    modport source (
        output valid, req_type, left_num, left_den, right_num, right_den,
        input  ready
    );

    modport sink (
        input  valid, req_type, left_num, left_den, right_num, right_den,
        output ready
    );
endinterface

>>> sv/rar_res_if.sv
// result channel: reduced fraction and divide error flag
interface rar_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [rar_pkg::PROD_WIDTH-1:0]  res_num;
    logic signed [rar_pkg::PROD_WIDTH-1:0]  res_den;
    logic                                   div_error;

    modport source (
        output valid, res_num, res_den, div_error,
        input  ready
    );

    modport sink (
        input  valid, res_num, res_den, div_error,
        output ready
    );
endinterface

>>> sv/rar_datapath.sv
// datapath: shared multiplier, binary gcd and two bit-serial exact dividers
module rar_datapath #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic [1:0]                            req_type,
    input  logic signed [OPERAND_WIDTH-1:0]       left_num,
    input  logic [OPERAND_WIDTH-2:0]              left_den,
    input  logic signed [OPERAND_WIDTH-1:0]       right_num,
    input  logic [OPERAND_WIDTH-2:0]              right_den,
    input  rar_pkg::cmd_t                         cmd,
    output rar_pkg::status_t                      status,
    output logic signed [rar_pkg::PROD_WIDTH-1:0] res_num,
    output logic signed [rar_pkg::PROD_WIDTH-1:0] res_den,
    output logic                                  div_error
);

    localparam int PW = rar_pkg::PROD_WIDTH;

    rar_pkg::op_t               op_reg;
    logic [PW-1:0]              ln_reg, ld_reg, rn_reg, rd_reg;
    logic [PW-1:0]              p1_reg, p2_reg, p3_reg;
    logic [PW-1:0]              mul_x, mul_y, mul_prod;
    logic [PW-1:0]              n_c, d_c, mag_n, mag_d;
    logic                       err_c;
    logic [PW-1:0]              a_reg, b_reg, a_next, b_next;
    logic [rar_pkg::SHIFT_WIDTH-1:0] k_reg, k_next;
    logic [PW-1:0]              mn_reg, md_reg, g_reg, g_c;
    logic                       num_neg_reg, den_neg_reg, err_reg, zero_reg;
    logic [PW-1:0]              rem_n_reg, rem_d_reg, qn_reg, qd_reg;
    logic [PW:0]                sn, sd, g_ext;
    logic [PW-1:0]              rem_n_next, rem_d_next;
    logic                       bit_n, bit_d;
    logic signed [PW-1:0]       num_out, den_out;

    // shared multiplier, low word only
    always_comb
    begin
        mul_x = ld_reg;
        mul_y = rd_reg;
        unique case (cmd.mul_phase)
            rar_pkg::MUL_P1:
            begin
                mul_x = ln_reg;
                mul_y = (op_reg == rar_pkg::OP_MUL) ? rn_reg : rd_reg;
            end
            rar_pkg::MUL_P2:
            begin
                mul_x = ld_reg;
                mul_y = (op_reg == rar_pkg::OP_MUL) ? rd_reg : rn_reg;
            end
            default:
            begin
                mul_x = ld_reg;
                mul_y = rd_reg;
            end
        endcase
        mul_prod = mul_x * mul_y;
    end

    // combine products into numerator and denominator
    always_comb
    begin
        case (op_reg)
            rar_pkg::OP_ADD: n_c = p1_reg + p2_reg;
            rar_pkg::OP_SUB: n_c = p1_reg - p2_reg;
            default:         n_c = p1_reg;
        endcase
        case (op_reg) inside
            rar_pkg::OP_ADD, rar_pkg::OP_SUB: d_c = p3_reg;
            default:                          d_c = p2_reg;
        endcase
        mag_n = n_c[PW-1] ? (~n_c + PW'(1)) : n_c;
        mag_d = d_c[PW-1] ? (~d_c + PW'(1)) : d_c;
        err_c = (op_reg == rar_pkg::OP_DIV) && ((ld_reg == '0) || (rn_reg == '0));
    end

    assign status.skip     = err_c || (n_c == '0);
    assign status.gcd_done = (a_reg == '0) || (b_reg == '0);

    // one binary gcd step
    always_comb
    begin
        a_next = a_reg;
        b_next = b_reg;
        k_next = k_reg;
        if (!a_reg[0] && !b_reg[0])
        begin
            a_next = a_reg >> 1;
            b_next = b_reg >> 1;
            k_next = k_reg + rar_pkg::SHIFT_WIDTH'(1);
        end
        else if (!a_reg[0])
        begin
            a_next = a_reg >> 1;
        end
        else if (!b_reg[0])
        begin
            b_next = b_reg >> 1;
        end
        else if (a_reg >= b_reg)
        begin
            a_next = (a_reg - b_reg) >> 1;
        end
        else
        begin
            b_next = (b_reg - a_reg) >> 1;
        end
        g_c = (a_reg | b_reg) << k_reg;
    end

    // restoring divide step for both quotients
    always_comb
    begin
        g_ext = {1'b0, g_reg};
        sn    = {rem_n_reg, qn_reg[PW-1]};
        sd    = {rem_d_reg, qd_reg[PW-1]};
        bit_n = (sn >= g_ext);
        bit_d = (sd >= g_ext);
        rem_n_next = bit_n ? PW'(sn - g_ext) : sn[PW-1:0];
        rem_d_next = bit_d ? PW'(sd - g_ext) : sd[PW-1:0];
    end

    always_comb
    begin
        if (err_reg)
        begin
            num_out = '0;
            den_out = '0;
        end
        else if (zero_reg)
        begin
            num_out = '0;
            den_out = PW'(1);
        end
        else
        begin
            num_out = num_neg_reg ? (~qn_reg + PW'(1)) : qn_reg;
            den_out = den_neg_reg ? (~qd_reg + PW'(1)) : qd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg <= rar_pkg::op_t'(req_type);
            ln_reg <= PW'(left_num);
            ld_reg <= PW'(left_den);
            rn_reg <= PW'(right_num);
            rd_reg <= PW'(right_den);
        end
        if (cmd.mul_en)
        begin
            unique case (cmd.mul_phase)
                rar_pkg::MUL_P1: p1_reg <= mul_prod;
                rar_pkg::MUL_P2: p2_reg <= mul_prod;
                default:         p3_reg <= mul_prod;
            endcase
        end
        if (cmd.setup)
        begin
            a_reg       <= mag_n;
            b_reg       <= mag_d;
            mn_reg      <= mag_n;
            md_reg      <= mag_d;
            k_reg       <= '0;
            num_neg_reg <= n_c[PW-1];
            den_neg_reg <= d_c[PW-1];
            err_reg     <= err_c;
            zero_reg    <= (n_c == '0);
        end
        else if (cmd.gcd_step)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            k_reg <= k_next;
        end
        if (cmd.div_init)
        begin
            g_reg     <= g_c;
            rem_n_reg <= '0;
            rem_d_reg <= '0;
            qn_reg    <= mn_reg;
            qd_reg    <= md_reg;
        end
        else if (cmd.div_step)
        begin
            rem_n_reg <= rem_n_next;
            rem_d_reg <= rem_d_next;
            qn_reg    <= {qn_reg[PW-2:0], bit_n};
            qd_reg    <= {qd_reg[PW-2:0], bit_d};
        end
        if (cmd.out_load)
        begin
            res_num   <= num_out;
            res_den   <= den_out;
            div_error <= err_reg;
        end
    end

endmodule

>>> sv/rar_ctrl.sv
// controller: sequences multiply, gcd and divide phases, owns handshakes
module rar_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output rar_pkg::cmd_t     cmd,
    input  rar_pkg::status_t  status
);

    localparam int CW = rar_pkg::DIV_CNT_WIDTH;
    localparam logic [CW-1:0] DIV_LAST = CW'(rar_pkg::PROD_WIDTH - 1);

    rar_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   div_cnt_reg, div_cnt_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::ST_IDLE:  if (in_valid) state_next = rar_pkg::ST_MUL1;
            rar_pkg::ST_MUL1:  state_next = rar_pkg::ST_MUL2;
            rar_pkg::ST_MUL2:  state_next = rar_pkg::ST_MUL3;
            rar_pkg::ST_MUL3:  state_next = rar_pkg::ST_SETUP;
            rar_pkg::ST_SETUP: state_next = status.skip ? rar_pkg::ST_FIN : rar_pkg::ST_GCD;
            rar_pkg::ST_GCD:   if (status.gcd_done) state_next = rar_pkg::ST_DIV;
            rar_pkg::ST_DIV:   if (div_cnt_reg == DIV_LAST) state_next = rar_pkg::ST_FIN;
            rar_pkg::ST_FIN:   if (out_free) state_next = rar_pkg::ST_IDLE;
            default:           state_next = rar_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        cmd.mul_phase  = rar_pkg::MUL_P1;
        in_ready       = 1'b0;
        div_cnt_next   = '0;
        unique case (state_reg)
            rar_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
            end
            rar_pkg::ST_MUL1:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = rar_pkg::MUL_P1;
            end
            rar_pkg::ST_MUL2:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = rar_pkg::MUL_P2;
            end
            rar_pkg::ST_MUL3:
            begin
                cmd.mul_en    = 1'b1;
                cmd.mul_phase = rar_pkg::MUL_P3;
            end
            rar_pkg::ST_SETUP:
            begin
                cmd.setup = 1'b1;
            end
            rar_pkg::ST_GCD:
            begin
                cmd.div_init = status.gcd_done;
                cmd.gcd_step = !status.gcd_done;
            end
            rar_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                div_cnt_next = div_cnt_reg + CW'(1);
            end
            rar_pkg::ST_FIN:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rar_pkg::ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // divider count only runs inside the divide phase
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != rar_pkg::ST_DIV |-> div_cnt_reg == '0)
        else $error("divide counter nonzero outside divide phase");

    // a new result appears only from the finish state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rar_pkg::ST_FIN)
        else $error("result valid raised outside finish state");

    // an accepted request starts the multiply phase
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == rar_pkg::ST_MUL1)
        else $error("accepted request did not start multiply phase");

    // finish state never leaves without loading the output register
    a_fin: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == rar_pkg::ST_FIN && state_next == rar_pkg::ST_IDLE |=> out_valid_reg)
        else $error("finish left without a result");

endmodule

>>> sv/rational_arith_reduce_top.sv
// top level of the rational arithmetic and reduction block
//
// req channel: one request carries an operation (add, subtract, multiply,
// divide) and two fractions with signed numerators and unsigned
// denominators. res channel: one result per request, the sum, difference,
// product or quotient, reduced to lowest terms by the gcd of the magnitudes,
// with div_error set when a divide meets a zero right numerator or a zero
// left denominator. one request is worked on at a time: the shared
// multiplier forms its products in states MUL1, MUL2 and MUL3, then the
// SETUP state runs, then a binary gcd of one step per cycle, latched when
// the loop ends, then bit-serial division of both quotients and a load
// into the output register. the time from accept to result valid is
// shortest for a zero numerator or refused divide, which skip the gcd and
// the division; otherwise the gcd loop sets its spread. with a ready
// receiver the next request is taken in the cycle after the result is
// loaded. the output register holds a finished result while the receiver
// stalls, and a new request is accepted meanwhile; the next result waits
// in the finish state until the register is free.
// reset clears the controller and drops res.valid; no clearing pass.
module rational_arith_reduce_top #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input logic    clk,
    input logic    rst_n,
    rar_req_if.sink  req,
    rar_res_if.source res
);

    rar_pkg::cmd_t    cmd;
    rar_pkg::status_t status;

    rar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .cmd       (cmd),
        .status    (status)
    );

    rar_datapath #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .req_type  (req.req_type),
        .left_num  (req.left_num),
        .left_den  (req.left_den),
        .right_num (req.right_num),
        .right_den (req.right_den),
        .cmd       (cmd),
        .status    (status),
        .res_num   (res.res_num),
        .res_den   (res.res_den),
        .div_error (res.div_error)
    );

endmodule

>>> dv/testbench.sv
// testbench for rational_arith_reduce_top: random and corner fraction requests
`timescale 1ns / 100ps

typedef struct packed {
    rar_pkg::op_t                                 op;
    logic signed [rar_pkg::OPERAND_WIDTH_DEF-1:0] left_num;
    logic [rar_pkg::OPERAND_WIDTH_DEF-2:0]        left_den;
    logic signed [rar_pkg::OPERAND_WIDTH_DEF-1:0] right_num;
    logic [rar_pkg::OPERAND_WIDTH_DEF-2:0]        right_den;
} frac_request_t;

typedef struct packed {
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic               div_error;
} frac_result_t;

class frac_scoreboard;
    frac_result_t expected_fractions[$];
    int           mismatches;
    int           requests_seen;
    int           results_checked;
    int           refused_divides;
    int           zero_results;

    function new();
        mismatches      = 0;
        requests_seen   = 0;
        results_checked = 0;
        refused_divides = 0;
        zero_results    = 0;
    endfunction

    function frac_result_t reduced_fraction(frac_request_t r);
        longint       ln;
        longint       ld;
        longint       rn;
        longint       rd;
        longint       n;
        longint       d;
        bit [31:0]    n32;
        bit [31:0]    d32;
        bit [31:0]    mn;
        bit [31:0]    md;
        bit [31:0]    x;
        bit [31:0]    y;
        bit [31:0]    t;
        bit [31:0]    qn;
        bit [31:0]    qd;
        frac_result_t res;
        ln  = longint'($signed(r.left_num));
        ld  = longint'(r.left_den);
        rn  = longint'($signed(r.right_num));
        rd  = longint'(r.right_den);
        res = '0;
        case (r.op)
            rar_pkg::OP_ADD:
            begin
                n = ln * rd + ld * rn;
                d = ld * rd;
            end
            rar_pkg::OP_SUB:
            begin
                n = ln * rd - ld * rn;
                d = ld * rd;
            end
            rar_pkg::OP_MUL:
            begin
                n = ln * rn;
                d = ld * rd;
            end
            default:
            begin
                n = ln * rd;
                d = ld * rn;
                if (ld == 0 || rn == 0)
                    res.div_error = 1'b1;
            end
        endcase
        if (res.div_error)
            return res;
        n32 = n[31:0];
        d32 = d[31:0];
        if (n32 == 0)
        begin
            res.den = 32'sd1;
            return res;
        end
        mn = n32[31] ? -n32 : n32;
        md = d32[31] ? -d32 : d32;
        x  = mn;
        y  = md;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        qn      = mn / x;
        qd      = md / x;
        res.num = n32[31] ? -qn : qn;
        res.den = d32[31] ? -qd : qd;
        return res;
    endfunction

    function void note_request(frac_request_t r);
        frac_result_t e;
        e = reduced_fraction(r);
        requests_seen++;
        if (e.div_error)
            refused_divides++;
        else if (e.num == 0)
            zero_results++;
        expected_fractions.push_back(e);
    endfunction

    function void check_result(frac_result_t act);
        frac_result_t e;
        results_checked++;
        if (expected_fractions.size() == 0)
        begin
            mismatches++;
            $display("%0t unexpected result: expected none, actual %0d/%0d err %0b",
                     $time, act.num, act.den, act.div_error);
            return;
        end
        e = expected_fractions.pop_front();
        if (act.num !== e.num)
        begin
            mismatches++;
            $display("%0t res_num mismatch: expected %0d, actual %0d", $time, e.num, act.num);
        end
        if (act.den !== e.den)
        begin
            mismatches++;
            $display("%0t res_den mismatch: expected %0d, actual %0d", $time, e.den, act.den);
        end
        if (act.div_error !== e.div_error)
        begin
            mismatches++;
            $display("%0t div_error mismatch: expected %0b, actual %0b",
                     $time, e.div_error, act.div_error);
        end
    endfunction

    function int outstanding();
        return expected_fractions.size();
    endfunction
endclass

module testbench;

    localparam int OW          = rar_pkg::OPERAND_WIDTH_DEF;
    localparam int RANDOM_REQS = 1450;

    logic clk;
    logic rst_n;
    bit   long_hold_done;

    frac_scoreboard sb = new();

    rar_req_if #(.OPERAND_WIDTH(OW)) req_ch();
    rar_res_if                       res_ch();

    rational_arith_reduce_top #(.OPERAND_WIDTH(OW)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(8_000_000);
        $display("[rational_arith_reduce_top] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sb.note_request('{rar_pkg::op_t'(req_ch.req_type), req_ch.left_num,
                              req_ch.left_den, req_ch.right_num, req_ch.right_den});
        if (rst_n && res_ch.valid && res_ch.ready)
            sb.check_result('{res_ch.res_num, res_ch.res_den, res_ch.div_error});
    end

    function automatic frac_request_t fraction_pair(rar_pkg::op_t op, int ln, int ld,
                                                    int rn, int rd);
        frac_request_t r;
        r.op        = op;
        r.left_num  = ln[OW-1:0];
        r.left_den  = ld[OW-2:0];
        r.right_num = rn[OW-1:0];
        r.right_den = rd[OW-2:0];
        return r;
    endfunction

    function automatic logic [OW-1:0] pick_num();
        case ($urandom_range(0, 9)) inside
            0:       return '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       return {1'b1, {(OW-1){1'b0}}};
                    1:       return '1;
                    2:       return OW'(1);
                    default: return {1'b0, {(OW-1){1'b1}}};
                endcase
            end
            [2:3]:   return OW'($urandom_range(0, 128)) - OW'(64);
            default: return OW'($urandom());
        endcase
    endfunction

    function automatic logic [OW-2:0] pick_den();
        case ($urandom_range(0, 49)) inside
            0:       return '0;
            [1:3]:   return '1;
            [4:9]:   return (OW-1)'($urandom_range(1, 64));
            default:
            begin
                logic [OW-2:0] v;
                v = (OW-1)'($urandom());
                return (v == '0) ? (OW-1)'(1) : v;
            end
        endcase
    endfunction

    function automatic frac_request_t random_request();
        frac_request_t r;
        r.op        = rar_pkg::op_t'($urandom_range(0, 3));
        r.left_num  = pick_num();
        r.left_den  = pick_den();
        r.right_num = pick_num();
        r.right_den = pick_den();
        return r;
    endfunction

    task automatic send_request(frac_request_t r);
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= r.op;
        req_ch.left_num  <= r.left_num;
        req_ch.left_den  <= r.left_den;
        req_ch.right_num <= r.right_num;
        req_ch.right_den <= r.right_den;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic pause_requests(int cycles);
        req_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // receiver: stretches of always-ready, coin-flip, sparse and mostly-ready
    initial
    begin
        int  mode;
        int  span;
        bit  rdy;
        res_ch.ready   <= 1'b0;
        long_hold_done = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 300);
            repeat (span)
            begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = $urandom_range(0, 1);
                    2:       rdy = ($urandom_range(0, 7) == 0);
                    default: rdy = ($urandom_range(0, 3) != 0);
                endcase
                res_ch.ready <= rdy;
                @(posedge clk);
            end
            // long back-pressure so the block fills and stalls its input
            if (!long_hold_done && sb.results_checked >= 200)
            begin
                res_ch.ready <= 1'b0;
                repeat (800) @(posedge clk);
                long_hold_done = 1'b1;
            end
        end
    end

    initial
    begin
        frac_request_t directed[$];
        int            sent;
        int            burst;
        rst_n            <= 1'b0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= rar_pkg::OP_ADD;
        req_ch.left_num  <= '0;
        req_ch.left_den  <= '0;
        req_ch.right_num <= '0;
        req_ch.right_den <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed.push_back(fraction_pair(rar_pkg::OP_ADD, -32768, 32767, -32768, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_ADD, 32767, 32767, 32767, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_ADD, 32767, 32766, 1, 32765));
        directed.push_back(fraction_pair(rar_pkg::OP_SUB, 32767, 32767, -32768, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_SUB, 1234, 5, 1234, 5));
        directed.push_back(fraction_pair(rar_pkg::OP_SUB, -32768, 1, 32767, 1));
        directed.push_back(fraction_pair(rar_pkg::OP_MUL, -32768, 1, -32768, 1));
        directed.push_back(fraction_pair(rar_pkg::OP_MUL, 12345, 1, 1, 12345));
        directed.push_back(fraction_pair(rar_pkg::OP_MUL, 0, 32767, -32768, 3));
        directed.push_back(fraction_pair(rar_pkg::OP_MUL, -1, 32767, -1, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 5, 7, 0, 3));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 5, 0, 2, 3));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 0, 0, 0, 0));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 3, 4, -9, 8));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, -32768, 1, -1, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 0, 9, -5, 2));
        directed.push_back(fraction_pair(rar_pkg::OP_DIV, 32767, 32767, -32768, 32767));
        directed.push_back(fraction_pair(rar_pkg::OP_ADD, 5, 0, 3, 7));
        directed.push_back(fraction_pair(rar_pkg::OP_SUB, -6, 0, 4, 0));
        directed.push_back(fraction_pair(rar_pkg::OP_MUL, 0, 0, 7, 0));
        directed.push_back(fraction_pair(rar_pkg::OP_SUB, 0, 0, 0, 0));
        directed.push_back(fraction_pair(rar_pkg::OP_ADD, 0, 1, 0, 1));
        foreach (directed[i])
            send_request(directed[i]);
        pause_requests(20);

        sent = 0;
        while (sent < RANDOM_REQS)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                if (sent < RANDOM_REQS)
                begin
                    send_request(random_request());
                    sent++;
                end
            end
            if ($urandom_range(0, 3) != 0)
                pause_requests($urandom_range(1, 40));
        end
        req_ch.valid <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (120) @(posedge clk);

        $display("covered %0d requests of all four operations, %0d results checked",
                 sb.requests_seen, sb.results_checked);
        $display("including %0d refused divides and %0d zero results, with long back-pressure",
                 sb.refused_divides, sb.zero_results);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("[rational_arith_reduce_top] OK");
        else
            $display("[rational_arith_reduce_top] ERROR");
        $finish;
    end

endmodule

>>> rational_arith_reduce_top.f
sv/rar_pkg.sv
sv/rar_req_if.sv
sv/rar_res_if.sv
sv/rar_datapath.sv
sv/rar_ctrl.sv
sv/rational_arith_reduce_top.sv
dv/testbench.sv
